// ----- rtl/core/bdcl_pkg.sv -----
package bdcl_pkg;

  typedef enum logic [2:0] {
    EV_DOWN   = 3'd0,
    EV_UP     = 3'd1,
    EV_CLICK  = 3'd2,
    EV_LONG   = 3'd3,
    EV_HOLD   = 3'd4,
    EV_UNLONG = 3'd5
  } event_t;

  // what one debounced scan asks the back end to report
  typedef enum logic [2:0] {
    ACT_DOWN      = 3'd0,
    ACT_LONG_HOLD = 3'd1,
    ACT_HOLD      = 3'd2,
    ACT_UP_CLICK  = 3'd3,
    ACT_UNLONG    = 3'd4
  } act_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ANALOG    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_TARGET = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_DELTA  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONGPRESS_MS  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_ID     = 8'd6;

  localparam logic [15:0] LONGPRESS_RST = 16'd1000;
  localparam logic [7:0]  DEBOUNCE_RST  = 8'd20;

  typedef struct packed {
    logic        active_low;
    logic        use_analog;
    logic [9:0]  analog_target;
    logic [9:0]  analog_delta;
    logic [15:0] longpress_ms;
    logic [7:0]  settle_ms;
    logic [7:0]  button_id;
  } cfg_t;

  // handshake between queue and its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- rtl/core/bdcl_front.sv -----
module bdcl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  bdcl_pkg::cfg_t      cfg,
  input  logic                accept,
  input  logic                pin_level,
  input  logic [9:0]          adc_sample,
  input  logic [31:0]         now_ms,
  output logic                push,
  output bdcl_pkg::act_t      push_act
);

  logic        last_level_r, last_level_nxt;
  logic [31:0] deb_stamp_r, deb_stamp_nxt;
  logic [31:0] press_stamp_r, press_stamp_nxt;
  logic        long_r, long_nxt;
  logic        held_r, held_nxt;

  logic [9:0]  adiff;
  logic        level;
  logic        changed;
  logic [31:0] deb_dt;
  logic [31:0] press_dt;
  logic        debounced;
  logic        long_due;

  always_comb begin
    adiff = (adc_sample >= cfg.analog_target) ? adc_sample - cfg.analog_target
                                              : cfg.analog_target - adc_sample;
    if (cfg.use_analog) begin
      level = adiff < cfg.analog_delta;
    end else begin
      level = pin_level ^ cfg.active_low;
    end
    changed   = level != last_level_r;
    deb_dt    = now_ms - deb_stamp_r;
    press_dt  = now_ms - press_stamp_r;
    // a level change restarts the stamp, so elapsed time is zero then
    debounced = !changed && (deb_dt > {24'd0, cfg.settle_ms});
    long_due  = press_dt >= {16'd0, cfg.longpress_ms};
  end

  always_comb begin
    last_level_nxt  = last_level_r;
    deb_stamp_nxt   = deb_stamp_r;
    press_stamp_nxt = press_stamp_r;
    long_nxt        = long_r;
    held_nxt        = held_r;
    push            = 1'b0;
    push_act        = bdcl_pkg::ACT_DOWN;
    if (accept) begin
      last_level_nxt = level;
      if (changed) begin
        deb_stamp_nxt = now_ms;
      end
      if (debounced) begin
        if (level) begin
          if (!held_r) begin
            push            = 1'b1;
            push_act        = bdcl_pkg::ACT_DOWN;
            press_stamp_nxt = now_ms;
            held_nxt        = 1'b1;
          end else if (!long_r) begin
            if (long_due) begin
              push     = 1'b1;
              push_act = bdcl_pkg::ACT_LONG_HOLD;
              long_nxt = 1'b1;
            end
          end else begin
            push     = 1'b1;
            push_act = bdcl_pkg::ACT_HOLD;
          end
        end else if (held_r) begin
          push     = 1'b1;
          push_act = long_r ? bdcl_pkg::ACT_UNLONG : bdcl_pkg::ACT_UP_CLICK;
          long_nxt = 1'b0;
          held_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r  <= 1'b0;
      deb_stamp_r   <= 32'd0;
      press_stamp_r <= 32'd0;
      long_r        <= 1'b0;
      held_r        <= 1'b0;
    end else begin
      last_level_r  <= last_level_nxt;
      deb_stamp_r   <= deb_stamp_nxt;
      press_stamp_r <= press_stamp_nxt;
      long_r        <= long_nxt;
      held_r        <= held_nxt;
    end
  end

endmodule

// ----- rtl/core/bdcl_queue.sv -----
module bdcl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bdcl_pkg::act_t    push_act,
  input  logic              pop,
  output bdcl_pkg::act_t    pop_act,
  output bdcl_pkg::qstat_t  stat
);

  bdcl_pkg::act_t             mem_r [bdcl_pkg::QDEPTH];
  logic [bdcl_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [bdcl_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [bdcl_pkg::QAW:0]     count_r, count_nxt;
  logic                       do_push;
  logic                       do_pop;

  always_comb begin
    stat.full  = count_r == (bdcl_pkg::QAW+1)'(bdcl_pkg::QDEPTH);
    stat.empty = count_r == '0;
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    pop_act    = mem_r[rd_ptr_r];
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/bdcl_back.sv -----
module bdcl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bdcl_pkg::cfg_t    cfg,
  input  bdcl_pkg::qstat_t  qstat,
  input  bdcl_pkg::act_t    q_act,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [2:0]        out_event_res,
  output logic [7:0]        out_button,
  output logic              out_last
);

  logic             valid_r, valid_nxt;
  bdcl_pkg::event_t ev_r, ev_nxt;
  logic [7:0]       button_r, button_nxt;
  logic             last_r, last_nxt;
  logic             pend_r, pend_nxt;
  bdcl_pkg::event_t pend_ev_r, pend_ev_nxt;
  logic             take;

  always_comb begin
    take        = !valid_r || !out_stall;
    pop         = 1'b0;
    valid_nxt   = valid_r;
    ev_nxt      = ev_r;
    button_nxt  = button_r;
    last_nxt    = last_r;
    pend_nxt    = pend_r;
    pend_ev_nxt = pend_ev_r;
    if (take) begin
      if (pend_r) begin
        // second event of a two-event scan
        valid_nxt = 1'b1;
        ev_nxt    = pend_ev_r;
        last_nxt  = 1'b1;
        pend_nxt  = 1'b0;
      end else if (!qstat.empty) begin
        pop        = 1'b1;
        valid_nxt  = 1'b1;
        button_nxt = cfg.button_id;
        last_nxt   = 1'b1;
        case (q_act)
          bdcl_pkg::ACT_DOWN: begin
            ev_nxt = bdcl_pkg::EV_DOWN;
          end
          bdcl_pkg::ACT_LONG_HOLD: begin
            ev_nxt      = bdcl_pkg::EV_LONG;
            last_nxt    = 1'b0;
            pend_nxt    = 1'b1;
            pend_ev_nxt = bdcl_pkg::EV_HOLD;
          end
          bdcl_pkg::ACT_HOLD: begin
            ev_nxt = bdcl_pkg::EV_HOLD;
          end
          bdcl_pkg::ACT_UP_CLICK: begin
            ev_nxt      = bdcl_pkg::EV_UP;
            last_nxt    = 1'b0;
            pend_nxt    = 1'b1;
            pend_ev_nxt = bdcl_pkg::EV_CLICK;
          end
          bdcl_pkg::ACT_UNLONG: begin
            ev_nxt = bdcl_pkg::EV_UNLONG;
          end
          default: begin
            ev_nxt = bdcl_pkg::EV_HOLD;
          end
        endcase
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r      <= ev_nxt;
    button_r  <= button_nxt;
    last_r    <= last_nxt;
    pend_ev_r <= pend_ev_nxt;
  end

  assign out_valid     = valid_r;
  assign out_event_res = ev_r;
  assign out_button    = button_r;
  assign out_last      = last_r;

endmodule

// ----- rtl/core/button_debounce_click_longpress.sv -----
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | in_pin_level, in_adc_sample, in_now_ms
// out     | output    | out_valid/out_stall | out_event_res, out_button, out_last
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a scan is taken whenever the four-entry action queue has room;
// a scan whose result is one event leaves as a single transfer from the output register,
// a scan with two events (longpress+hold, up+click) occupies the output register
// for both of its events in turn, and the next queued action waits until both have left.
// synchronous active-low reset clears debounce/press state and the queue;
// out_stall holds the output register, in_stall rises only when the queue is full.
module button_debounce_click_longpress (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_pin_level,
  input  logic [9:0]                         in_adc_sample,
  input  logic [31:0]                        in_now_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_event_res,
  output logic [7:0]                         out_button,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdcl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bdcl_pkg::cfg_t   cfg_r, cfg_nxt;
  bdcl_pkg::qstat_t qstat;
  bdcl_pkg::act_t   push_act;
  bdcl_pkg::act_t   pop_act;
  logic             push;
  logic             pop;
  logic             accept;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        bdcl_pkg::CFG_ACTIVE_LOW:    cfg_nxt.active_low    = cfg_data[0];
        bdcl_pkg::CFG_USE_ANALOG:    cfg_nxt.use_analog    = cfg_data[0];
        bdcl_pkg::CFG_ANALOG_TARGET: cfg_nxt.analog_target = cfg_data[9:0];
        bdcl_pkg::CFG_ANALOG_DELTA:  cfg_nxt.analog_delta  = cfg_data[9:0];
        bdcl_pkg::CFG_LONGPRESS_MS:  cfg_nxt.longpress_ms  = cfg_data[15:0];
        bdcl_pkg::CFG_DEBOUNCE_MS:   cfg_nxt.settle_ms     = cfg_data[7:0];
        bdcl_pkg::CFG_BUTTON_ID:     cfg_nxt.button_id     = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low    <= 1'b1;
      cfg_r.use_analog    <= 1'b0;
      cfg_r.analog_target <= 10'd0;
      cfg_r.analog_delta  <= 10'd0;
      cfg_r.longpress_ms  <= bdcl_pkg::LONGPRESS_RST;
      cfg_r.settle_ms     <= bdcl_pkg::DEBOUNCE_RST;
      cfg_r.button_id     <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;

  bdcl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .pin_level  (in_pin_level),
    .adc_sample (in_adc_sample),
    .now_ms     (in_now_ms),
    .push       (push),
    .push_act   (push_act)
  );

  bdcl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_act (push_act),
    .pop      (pop),
    .pop_act  (pop_act),
    .stat     (qstat)
  );

  bdcl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .qstat         (qstat),
    .q_act         (pop_act),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_event_res (out_event_res),
    .out_button    (out_button),
    .out_last      (out_last)
  );

endmodule

// ----- verif/tb_button_debounce_click_longpress.sv -----
`timescale 1ns / 1ps

module tb_button_debounce_click_longpress;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASE_SCANS = 148;
  localparam logic [bdcl_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd7;

  typedef struct {
    logic        pin;
    logic [9:0]  adc;
    logic [31:0] stamp;
  } scan_t;

  typedef struct {
    bdcl_pkg::event_t ev;
    logic [7:0]       button;
    logic             last;
  } report_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_pin_level = 1'b0;
  logic [9:0]                      in_adc_sample = '0;
  logic [31:0]                     in_now_ms = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [2:0]                      out_event_res;
  logic [7:0]                      out_button;
  logic                            out_last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bdcl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bdcl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  button_debounce_click_longpress uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pin_level  (in_pin_level),
    .in_adc_sample (in_adc_sample),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_button    (out_button),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  scan_t   scans_to_send[$];
  scan_t   next_scan;
  report_t pending_events[$];

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int fails = 0;
  int cycle_count = 0;
  int scans_queued = 0;
  logic [31:0] clock_ms = 32'd100;

  // predicted configuration and debounce state of the button
  bdcl_pkg::cfg_t model_cfg = '{active_low: 1'b1, use_analog: 1'b0, analog_target: 10'd0,
                                analog_delta: 10'd0, longpress_ms: bdcl_pkg::LONGPRESS_RST,
                                settle_ms: bdcl_pkg::DEBOUNCE_RST, button_id: 8'd0};
  bdcl_pkg::cfg_t phase_cfg;
  logic        prev_level = 1'b0;
  logic [31:0] stable_since = '0;
  logic [31:0] press_at = '0;
  logic        long_seen = 1'b0;
  logic        held = 1'b0;

  function automatic void predict_events(input logic pin, input logic [9:0] adc,
                                         input logic [31:0] stamp);
    logic             level;
    logic [9:0]       gap;
    bdcl_pkg::event_t evs[$];
    report_t          r;
    if (model_cfg.use_analog) begin
      gap = (adc >= model_cfg.analog_target) ? adc - model_cfg.analog_target
                                             : model_cfg.analog_target - adc;
      level = gap < model_cfg.analog_delta;
    end else begin
      level = pin ^ model_cfg.active_low;
    end
    if (level != prev_level) stable_since = stamp;
    if (stamp - stable_since > 32'(model_cfg.settle_ms)) begin
      if (level) begin
        if (held) begin
          if (!long_seen && (stamp - press_at >= 32'(model_cfg.longpress_ms))) begin
            long_seen = 1'b1;
            evs.push_back(bdcl_pkg::EV_LONG);
          end
          if (long_seen) evs.push_back(bdcl_pkg::EV_HOLD);
        end else begin
          evs.push_back(bdcl_pkg::EV_DOWN);
          press_at = stamp;
          held = 1'b1;
        end
      end else if (held) begin
        if (!long_seen) begin
          evs.push_back(bdcl_pkg::EV_UP);
          evs.push_back(bdcl_pkg::EV_CLICK);
        end else begin
          evs.push_back(bdcl_pkg::EV_UNLONG);
          long_seen = 1'b0;
        end
        held = 1'b0;
      end
    end
    prev_level = level;
    foreach (evs[i]) begin
      r.ev = evs[i];
      r.button = model_cfg.button_id;
      r.last = (i == evs.size() - 1);
      pending_events.push_back(r);
    end
  endfunction

  // scan driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_events(in_pin_level, in_adc_sample, in_now_ms);
      if (!in_valid || !in_stall) begin
        if (scans_to_send.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          next_scan = scans_to_send.pop_front();
          in_valid <= 1'b1;
          in_pin_level <= next_scan.pin;
          in_adc_sample <= next_scan.adc;
          in_now_ms <= next_scan.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // event monitor
  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $error("unexpected event transfer: event_res=%0d button=%0d last=%0d",
                 out_event_res, out_button, out_last);
          fails++;
        end else begin
          want = pending_events.pop_front();
          if (out_event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, out_event_res);
            fails++;
          end
          if (out_button !== want.button) begin
            $error("button: expected %0d, got %0d", want.button, out_button);
            fails++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            fails++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_scan(input logic pin, input logic [9:0] adc, input logic [31:0] stamp);
    scan_t s;
    s.pin = pin;
    s.adc = adc;
    s.stamp = stamp;
    scans_to_send.push_back(s);
    scans_queued++;
  endtask

  // sample that lands inside or outside the analog window
  function automatic logic [9:0] adc_for(input logic pressed);
    int t, d, lo, hi;
    t = int'(phase_cfg.analog_target);
    d = int'(phase_cfg.analog_delta);
    if (pressed && d > 0) begin
      lo = (t - d + 1 < 0) ? 0 : t - d + 1;
      hi = (t + d - 1 > 1023) ? 1023 : t + d - 1;
      return 10'($urandom_range(hi, lo));
    end
    if (!pressed && t - d >= 0 && (t + d > 1023 || $urandom_range(0, 1) == 1))
      return 10'($urandom_range(t - d, 0));
    if (!pressed && t + d <= 1023) return 10'($urandom_range(1023, t + d));
    return 10'($urandom);
  endfunction

  task automatic add_level(input logic pressed, input int unsigned dt);
    clock_ms += dt;
    if (phase_cfg.use_analog) push_scan(1'($urandom_range(0, 1)), adc_for(pressed), clock_ms);
    else push_scan(pressed ^ phase_cfg.active_low, 10'($urandom), clock_ms);
  endtask

  // bounce, stable press with random hold, bounce, stable release
  task automatic add_episode();
    int unsigned deb, lp;
    int n;
    deb = 32'(phase_cfg.settle_ms);
    lp = 32'(phase_cfg.longpress_ms);
    n = $urandom_range(0, 3);
    repeat (n) add_level(1'($urandom_range(0, 1)), $urandom_range(0, deb / 2));
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) add_level(1'b1, $urandom_range(0, lp + lp / 4 + 5));
      else add_level(1'b1, $urandom_range(0, deb + 3));
    end
    n = $urandom_range(0, 2);
    repeat (n) add_level(1'($urandom_range(0, 1)), $urandom_range(0, deb / 2));
    n = $urandom_range(1, 3);
    repeat (n) add_level(1'b0, $urandom_range(0, deb + 3));
  endtask

  task automatic write_reg(input logic [bdcl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value, input int width);
    logic [15:0] word;
    word = 16'($urandom);
    word = value | (word << width);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bdcl_pkg::CFG_ACTIVE_LOW:    model_cfg.active_low = word[0];
      bdcl_pkg::CFG_USE_ANALOG:    model_cfg.use_analog = word[0];
      bdcl_pkg::CFG_ANALOG_TARGET: model_cfg.analog_target = word[9:0];
      bdcl_pkg::CFG_ANALOG_DELTA:  model_cfg.analog_delta = word[9:0];
      bdcl_pkg::CFG_LONGPRESS_MS:  model_cfg.longpress_ms = word;
      bdcl_pkg::CFG_DEBOUNCE_MS:   model_cfg.settle_ms = word[7:0];
      bdcl_pkg::CFG_BUTTON_ID:     model_cfg.button_id = word[7:0];
      default: ;
    endcase
  endtask

  // must start at a rising edge; upper data bits carry junk the block must drop
  task automatic set_config(input bdcl_pkg::cfg_t c);
    phase_cfg = c;
    write_reg(bdcl_pkg::CFG_ACTIVE_LOW, 16'(c.active_low), 1);
    write_reg(bdcl_pkg::CFG_USE_ANALOG, 16'(c.use_analog), 1);
    write_reg(bdcl_pkg::CFG_ANALOG_TARGET, 16'(c.analog_target), 10);
    write_reg(bdcl_pkg::CFG_ANALOG_DELTA, 16'(c.analog_delta), 10);
    write_reg(bdcl_pkg::CFG_LONGPRESS_MS, c.longpress_ms, 16);
    write_reg(bdcl_pkg::CFG_DEBOUNCE_MS, 16'(c.settle_ms), 8);
    write_reg(bdcl_pkg::CFG_BUTTON_ID, 16'(c.button_id), 8);
    write_reg(CFG_IDX_SPARE | 8'($urandom), 16'($urandom), 16);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every predicted event has been seen
  task automatic drain();
    do @(posedge clk);
    while (scans_to_send.size() != 0 || in_valid || pending_events.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    bdcl_pkg::cfg_t c;
    phase_cfg = model_cfg;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 14;
    out_idle_pct = 82;

    // reset settings: active-low pin, 20 ms debounce, 1000 ms longpress
    push_scan(1'b1, 10'd0, 32'd0);
    push_scan(1'b1, 10'd1023, 32'd100);
    push_scan(1'b0, 10'd0, 32'd200);
    push_scan(1'b0, 10'd1023, 32'd221);
    push_scan(1'b0, 10'd0, 32'd500);
    push_scan(1'b1, 10'd1023, 32'd510);
    push_scan(1'b1, 10'd0, 32'd531);
    push_scan(1'b0, 10'd1023, 32'd600);
    push_scan(1'b0, 10'd0, 32'd700);
    push_scan(1'b0, 10'd1023, 32'd1700);
    push_scan(1'b0, 10'd0, 32'd1800);
    push_scan(1'b1, 10'd1023, 32'd1900);
    push_scan(1'b1, 10'd0, 32'd2000);
    // debounce across the timestamp wrap
    push_scan(1'b0, 10'd1023, 32'hFFFF_FFF0);
    push_scan(1'b0, 10'd0, 32'h0000_0010);
    push_scan(1'b1, 10'd1023, 32'h0000_0020);
    push_scan(1'b1, 10'd0, 32'h0000_0040);
    drain();

    // analog window edges, zero debounce, zero longpress
    set_config('{active_low: 1'b0, use_analog: 1'b1, analog_target: 10'd512,
                 analog_delta: 10'd3, longpress_ms: 16'd0, settle_ms: 8'd0,
                 button_id: 8'd255});
    push_scan(1'($urandom_range(0, 1)), 10'd514, 32'd10);
    push_scan(1'($urandom_range(0, 1)), 10'd510, 32'd11);
    push_scan(1'($urandom_range(0, 1)), 10'd512, 32'd12);
    push_scan(1'($urandom_range(0, 1)), 10'd515, 32'd13);
    push_scan(1'($urandom_range(0, 1)), 10'd509, 32'd14);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: c = '{active_low: 1'b1, use_analog: 1'b0, analog_target: 10'($urandom),
                 analog_delta: 10'($urandom), longpress_ms: 16'd1000, settle_ms: 8'd20,
                 button_id: 8'($urandom)};
        1: c = '{active_low: 1'b0, use_analog: 1'b0, analog_target: 10'd1023,
                 analog_delta: 10'd0, longpress_ms: 16'd0, settle_ms: 8'd0,
                 button_id: 8'd255};
        2: c = '{active_low: 1'b1, use_analog: 1'b1, analog_target: 10'd0,
                 analog_delta: 10'd1023, longpress_ms: 16'($urandom_range(0, 300)),
                 settle_ms: 8'd5, button_id: 8'd0};
        3: c = '{active_low: 1'b0, use_analog: 1'b1, analog_target: 10'd1023,
                 analog_delta: 10'd40, longpress_ms: 16'd65535, settle_ms: 8'd255,
                 button_id: 8'($urandom)};
        4: c = '{active_low: 1'($urandom), use_analog: 1'b0, analog_target: 10'($urandom),
                 analog_delta: 10'($urandom), longpress_ms: 16'($urandom_range(0, 3000)),
                 settle_ms: 8'($urandom), button_id: 8'($urandom)};
        default: c = '{active_low: 1'($urandom), use_analog: 1'b1,
                       analog_target: 10'($urandom), analog_delta: 10'($urandom_range(1, 80)),
                       longpress_ms: 16'($urandom_range(0, 2000)),
                       settle_ms: 8'($urandom_range(0, 40)), button_id: 8'($urandom)};
      endcase
      if (p < 2) begin
        in_idle_pct = 14;
        out_idle_pct = 82;
      end else if (p < 4) begin
        in_idle_pct = 82;
        out_idle_pct = 14;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (p == 4) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      set_config(c);
      scans_queued = 0;
      while (scans_queued < PHASE_SCANS) begin
        if ($urandom_range(0, 9) == 0)
          push_scan(1'($urandom_range(0, 1)), 10'($urandom), $urandom);
        else
          add_episode();
      end
      drain();
    end

    if (fails == 0 && pending_events.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
